>>> design/lrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrw_pkg
// shared constants and control types of the least-recently-written map
// ----------------------------------------------------------------------------
package lrw_pkg;

   localparam int ENTRIES_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT   = 32;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam int CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic OP_PUT = 1'b0;
   localparam logic OP_GET = 1'b1;

   typedef struct packed {
      logic fire;
      logic op;
   } lrw_cmd_type;

   typedef struct packed {
      logic found;
      logic evicted;
   } lrw_stat_type;

endpackage

>>> design/lrw_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrw_table
// fully associative entry table: parallel key compare, write-age update,
// eviction of the oldest written entry and insertion into the first free slot
// ----------------------------------------------------------------------------
module lrw_table #(
   parameter int ENTRIES    = lrw_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS   = lrw_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lrw_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lrw_pkg::lrw_cmd_type          cmd,
   input  logic [lrw_pkg::CAP_BITS-1:0]  cap_limit,
   input  logic [KEY_BITS-1:0]           key,
   input  logic [VALUE_BITS-1:0]         value,
   output lrw_pkg::lrw_stat_type         stat,
   output logic [VALUE_BITS-1:0]         read_value
);

   localparam int AGE_BITS   = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);
   localparam int CMP_BITS   = (COUNT_BITS > lrw_pkg::CAP_BITS) ? COUNT_BITS
                                                                 : lrw_pkg::CAP_BITS;

   logic [ENTRIES-1:0]    valid_ff;
   logic [ENTRIES-1:0]    valid_in;
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] value_ff [ENTRIES];
   logic [AGE_BITS-1:0]   age_ff   [ENTRIES];
   logic [AGE_BITS-1:0]   age_in   [ENTRIES];
   logic [COUNT_BITS-1:0] live_ff;
   logic [COUNT_BITS-1:0] live_in;

   logic [ENTRIES-1:0]    match;
   logic [ENTRIES-1:0]    victim;
   logic [ENTRIES-1:0]    valid_after;
   logic [ENTRIES-1:0]    slot_oh;
   logic [ENTRIES-1:0]    wr_oh;
   logic                  hit;
   logic                  is_put;
   logic                  need_evict;
   logic [AGE_BITS-1:0]   hit_age;
   logic [AGE_BITS-1:0]   oldest_age;
   logic [COUNT_BITS-1:0] live_dec;
   logic [CMP_BITS-1:0]   cap_eff;
   logic [CMP_BITS-1:0]   live_cmp;
   logic [VALUE_BITS-1:0] hit_value;
   logic                  taken;

   // compare, victim and free slot
   always_comb begin
      hit_value = '0;
      hit_age   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == key);
         if (match[i]) begin
            hit_value = hit_value | value_ff[i];
            hit_age   = hit_age | age_ff[i];
         end
      end
      hit    = |match;
      is_put = (cmd.op == lrw_pkg::OP_PUT);

      cap_eff = CMP_BITS'(cap_limit);
      if (cap_eff == '0) begin
         cap_eff = CMP_BITS'(1);
      end
      if (cap_eff > CMP_BITS'(ENTRIES)) begin
         cap_eff = CMP_BITS'(ENTRIES);
      end
      live_cmp   = CMP_BITS'(live_ff);
      need_evict = is_put && !hit && (live_cmp >= cap_eff) && (live_ff != '0);

      // ages of live entries are distinct, oldest is live_count - 1
      live_dec   = live_ff - COUNT_BITS'(1);
      oldest_age = live_dec[AGE_BITS-1:0];
      for (int i = 0; i < ENTRIES; i++) begin
         victim[i] = valid_ff[i] && (age_ff[i] == oldest_age);
      end
      valid_after = need_evict ? (valid_ff & ~victim) : valid_ff;

      taken = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_oh[i] = !valid_after[i] && !taken;
         if (!valid_after[i]) begin
            taken = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      valid_in = valid_ff;
      live_in  = live_ff;
      wr_oh    = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         age_in[i] = age_ff[i];
      end
      if (cmd.fire && is_put) begin
         if (hit) begin
            wr_oh = match;
            for (int i = 0; i < ENTRIES; i++) begin
               if (match[i]) begin
                  age_in[i] = '0;
               end else if (valid_ff[i] && (age_ff[i] < hit_age)) begin
                  age_in[i] = age_ff[i] + AGE_BITS'(1);
               end
            end
         end else begin
            wr_oh    = slot_oh;
            valid_in = valid_after | slot_oh;
            live_in  = live_ff + COUNT_BITS'(1) - COUNT_BITS'(need_evict);
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_oh[i]) begin
                  age_in[i] = '0;
               end else if (valid_after[i]) begin
                  age_in[i] = age_ff[i] + AGE_BITS'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         live_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         live_ff  <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         age_ff[i] <= age_in[i];
         if (wr_oh[i]) begin
            value_ff[i] <= value;
            if (!hit) begin
               key_ff[i] <= key;
            end
         end
      end
   end

   assign stat.found   = hit;
   assign stat.evicted = need_evict;
   assign read_value   = (cmd.op == lrw_pkg::OP_GET) ? hit_value : '0;

endmodule

>>> design/lrw_bounded_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrw_bounded_map
// bounded key/value map with least-recently-written replacement
// ----------------------------------------------------------------------------
// usage:
//   req_*  one word per put (req_op 0) or get (req_op 1), valid/stall
//   rsp_*  one result word per request, in order: found, read_value, evicted
//   csr_*  write of capacity_limit, csr_ready is always high; write only
//          while no request is in flight
// timing:
//   one request per cycle sustained while rsp is not stalled; a request
//   accepted into the input register is looked up and applied to the
//   table when it advances, and its result is loaded into the output
//   register as it is applied
// reset:
//   table empty, capacity_limit 16, both stages empty
// stall:
//   a stalled result holds in the output register; one more request is
//   taken into the input register, then req_stall rises until rsp drains
// ----------------------------------------------------------------------------
module lrw_bounded_map #(
   parameter int ENTRIES    = lrw_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS   = lrw_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lrw_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_op,
   input  logic [KEY_BITS-1:0]           req_key,
   input  logic [VALUE_BITS-1:0]         req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [VALUE_BITS-1:0]         rsp_read_value,
   output logic                          rsp_evicted,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lrw_pkg::CAP_BITS-1:0]  csr_data
);

   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic                         s1_op_ff;
   logic [KEY_BITS-1:0]          s1_key_ff;
   logic [VALUE_BITS-1:0]        s1_value_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_found_ff;
   logic                         rsp_evicted_ff;
   logic [VALUE_BITS-1:0]        rsp_value_ff;
   logic [lrw_pkg::CAP_BITS-1:0] cap_ff;
   logic                         advance;
   logic                         req_take;
   lrw_pkg::lrw_cmd_type         cmd;
   lrw_pkg::lrw_stat_type        stat;
   logic [VALUE_BITS-1:0]        tbl_value;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign cmd.fire  = s1_valid_ff && advance;
   assign cmd.op    = s1_op_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (cmd.fire) begin
         s1_valid_in = 1'b0;
      end
   end

   lrw_table #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cap_limit  (cap_ff),
      .key        (s1_key_ff),
      .value      (s1_value_ff),
      .stat       (stat),
      .read_value (tbl_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= lrw_pkg::CAP_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= req_op;
         s1_key_ff   <= req_key;
         s1_value_ff <= req_value;
      end
      if (cmd.fire) begin
         rsp_found_ff   <= stat.found;
         rsp_evicted_ff <= stat.evicted;
         rsp_value_ff   <= tbl_value;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

   // checks
   a_evict_not_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_evicted_ff |-> !rsp_found_ff)
      else $error("eviction reported on a hit");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_value_ff == '0)
      else $error("nonzero read value on a miss");

   a_get_no_evict: assert property (@(posedge clock) disable iff (reset)
      cmd.fire && (s1_op_ff == lrw_pkg::OP_GET) |=> !rsp_evicted_ff)
      else $error("get caused an eviction");

   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |=> rsp_valid_ff)
      else $error("processed word produced no result");

endmodule
